// ===== rtl/bfp_pkg.sv =====
// shared types and constants for the lsb-first bit-field packer
package bfp_pkg;

    localparam int MAX_FIELD_BITS = 32;
    localparam int WIDTH_BITS     = 6;
    localparam int BYTE_BITS      = 8;
    localparam int CNT_BITS       = 3;
    localparam int ACC_BITS       = MAX_FIELD_BITS + BYTE_BITS;
    localparam int RUN_BITS       = 3;

    localparam logic [WIDTH_BITS-1:0] WIDTH_SAT = WIDTH_BITS'(MAX_FIELD_BITS);

    // run of bytes handed from the merge logic to the byte emitter
    typedef struct packed {
        logic [RUN_BITS-1:0] nbytes;
        logic [ACC_BITS-1:0] data;
    } bfp_run_t;

endpackage

// ===== rtl/lsb_first_bit_field_packer_core.sv =====
// top level of the lsb-first bit-field packer
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   cfg     | cfg_valid cfg_ready cfg_data[2:0]         | in
//   in      | in_valid in_ready field_width field_value | in
//           | flush                                     |
//   out     | out_valid out_ready out_byte last_of_run  | out
//
// an item is merged in the cycle it is accepted; its 0 to 5 bytes leave the
// result register one per cycle while out_ready is high.
// a new item is taken in the cycle the last byte of the previous run leaves.
// a stalled output holds its byte and blocks input once that run is pending.
// reset empties the result register and clears the partial byte to bit 0.
// cfg is always ready; a write restarts the stream at the new start bit.
module lsb_first_bit_field_packer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bfp_pkg::CNT_BITS-1:0]       cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bfp_pkg::WIDTH_BITS-1:0]     field_width,
    input  logic [bfp_pkg::MAX_FIELD_BITS-1:0] field_value,
    input  logic                               flush,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bfp_pkg::BYTE_BITS-1:0]      out_byte,
    output logic                               last_of_run
);

    logic [bfp_pkg::BYTE_BITS-1:0] pending_bits_reg;
    logic [bfp_pkg::BYTE_BITS-1:0] pending_bits_next;
    logic [bfp_pkg::CNT_BITS-1:0]  pending_count_reg;
    logic [bfp_pkg::CNT_BITS-1:0]  pending_count_next;
    logic [bfp_pkg::BYTE_BITS-1:0] merged_bits;
    logic [bfp_pkg::CNT_BITS-1:0]  merged_count;
    bfp_pkg::bfp_run_t             run;
    logic                          can_load;
    logic                          in_xfer;
    logic                          cfg_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_ready  = can_load;
    assign in_xfer   = in_valid && in_ready;

    // field merge
    bfp_merge u_merge (
        .pending_bits  (pending_bits_reg),
        .pending_count (pending_count_reg),
        .field_width   (field_width),
        .field_value   (field_value),
        .flush         (flush),
        .run           (run),
        .next_bits     (merged_bits),
        .next_count    (merged_count)
    );

    // byte emitter
    bfp_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_xfer && (run.nbytes != '0)),
        .run         (run),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // pending partial byte, a cfg write starts a new stream
    always_comb
    begin
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        if (cfg_xfer)
        begin
            pending_bits_next  = '0;
            pending_count_next = cfg_data;
        end
        else if (in_xfer)
        begin
            pending_bits_next  = merged_bits;
            pending_count_next = merged_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
        end
        else
        begin
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

// ===== rtl/bfp_merge.sv =====
// merges a new field into the pending partial byte and sizes the byte run
module bfp_merge (
    input  logic [bfp_pkg::BYTE_BITS-1:0]      pending_bits,
    input  logic [bfp_pkg::CNT_BITS-1:0]       pending_count,
    input  logic [bfp_pkg::WIDTH_BITS-1:0]     field_width,
    input  logic [bfp_pkg::MAX_FIELD_BITS-1:0] field_value,
    input  logic                               flush,
    output bfp_pkg::bfp_run_t                  run,
    output logic [bfp_pkg::BYTE_BITS-1:0]      next_bits,
    output logic [bfp_pkg::CNT_BITS-1:0]       next_count
);

    logic [bfp_pkg::WIDTH_BITS-1:0]     width_sat;
    logic [bfp_pkg::MAX_FIELD_BITS:0]   mask_wide;
    logic [bfp_pkg::MAX_FIELD_BITS-1:0] value_masked;
    logic [bfp_pkg::ACC_BITS-1:0]       acc;
    logic [bfp_pkg::WIDTH_BITS-1:0]     total;
    logic [bfp_pkg::RUN_BITS-1:0]       full;
    logic [bfp_pkg::CNT_BITS-1:0]       rem;
    logic [bfp_pkg::BYTE_BITS-1:0]      leftover;

    // saturate width and drop value bits above it
    always_comb
    begin
        width_sat    = (field_width > bfp_pkg::WIDTH_SAT) ? bfp_pkg::WIDTH_SAT : field_width;
        mask_wide    = ((bfp_pkg::MAX_FIELD_BITS+1)'(1) << width_sat)
                       - (bfp_pkg::MAX_FIELD_BITS+1)'(1);
        value_masked = field_value & mask_wide[bfp_pkg::MAX_FIELD_BITS-1:0];
    end

    // place the field above the pending bits
    always_comb
    begin
        acc   = bfp_pkg::ACC_BITS'(pending_bits)
              | (bfp_pkg::ACC_BITS'(value_masked) << pending_count);
        total = bfp_pkg::WIDTH_BITS'(pending_count) + width_sat;
        full  = total[bfp_pkg::WIDTH_BITS-1:bfp_pkg::CNT_BITS];
        rem   = total[bfp_pkg::CNT_BITS-1:0];
    end

    // bits left over after the completed bytes
    always_comb
    begin
        unique case (full)
            3'd0:    leftover = acc[7:0];
            3'd1:    leftover = acc[15:8];
            3'd2:    leftover = acc[23:16];
            3'd3:    leftover = acc[31:24];
            3'd4:    leftover = acc[39:32];
            default: leftover = '0;
        endcase
    end

    // byte run and next pending state, flush empties the partial byte
    always_comb
    begin
        run.data = acc;
        if (flush)
        begin
            run.nbytes = full + bfp_pkg::RUN_BITS'(rem != '0);
            next_bits  = '0;
            next_count = '0;
        end
        else
        begin
            run.nbytes = full;
            next_bits  = leftover;
            next_count = rem;
        end
    end

endmodule

// ===== rtl/bfp_emit.sv =====
// result register that sends a run of packed bytes one per cycle while out_ready is high
module bfp_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  bfp_pkg::bfp_run_t             run,
    output logic                          can_load,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bfp_pkg::BYTE_BITS-1:0] out_byte,
    output logic                          last_of_run
);

    logic [bfp_pkg::ACC_BITS-1:0] data_reg;
    logic [bfp_pkg::ACC_BITS-1:0] data_next;
    logic [bfp_pkg::RUN_BITS-1:0] left_reg;
    logic [bfp_pkg::RUN_BITS-1:0] left_next;
    logic                         out_xfer;

    // output side view of the register
    assign out_valid   = (left_reg != '0);
    assign last_of_run = (left_reg == bfp_pkg::RUN_BITS'(1));
    assign out_byte    = data_reg[bfp_pkg::BYTE_BITS-1:0];
    assign out_xfer    = out_valid && out_ready;
    assign can_load    = !out_valid || (last_of_run && out_ready);

    // a new run replaces the old one as its last byte leaves
    always_comb
    begin
        data_next = data_reg;
        left_next = left_reg;
        if (load)
        begin
            data_next = run.data;
            left_next = run.nbytes;
        end
        else if (out_xfer)
        begin
            data_next = data_reg >> bfp_pkg::BYTE_BITS;
            left_next = left_reg - bfp_pkg::RUN_BITS'(1);
        end
    end

    // byte count needs reset, data does not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/bfp_checker.sv =====
// port-level checks for the packer core and their bind
module bfp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [bfp_pkg::WIDTH_BITS-1:0]     field_width,
    input logic                               flush,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [bfp_pkg::BYTE_BITS-1:0]      out_byte,
    input logic                               last_of_run
);

    // a stalled byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("stalled output changed");

    // no byte appears without an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && in_ready) |=> !out_valid)
        else $error("output appeared without input");

    // an empty result register always takes input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output empty");

    // a run continues until its last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("run ended without last marker");

    // an empty field without flush makes no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && in_ready && (field_width == '0) && !flush |=> !out_valid)
        else $error("empty field produced a byte");

endmodule

bind lsb_first_bit_field_packer_core bfp_checker u_bfp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .field_width (field_width),
    .flush       (flush),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);

// ===== test/testbench.sv =====
// testbench for the lsb-first bit-field packer: directed and random fields, byte-level checking
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE_CYC  = 8;
    localparam int REPORT_MAX  = 10;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 25;

    // one byte of the packed stream
    typedef struct packed {
        logic [bfp_pkg::BYTE_BITS-1:0] data;
        logic                          last;
    } stream_byte_t;

    // tracks the partial byte and holds the bytes the packer still owes
    class byte_stream_checker;
        logic [bfp_pkg::BYTE_BITS-1:0] partial_byte;
        logic [bfp_pkg::CNT_BITS-1:0]  fill_count;
        stream_byte_t                  bytes_due[$];
        int                            errors;

        function new();
            partial_byte = '0;
            fill_count   = '0;
            errors       = 0;
        endfunction

        // a start bit write opens a new stream and drops any partial byte
        function void restart(logic [bfp_pkg::CNT_BITS-1:0] start_bit);
            partial_byte = '0;
            fill_count   = start_bit;
        endfunction

        // append one accepted field and queue the bytes it completes
        function void append_field(logic [bfp_pkg::WIDTH_BITS-1:0] width_in,
                                   logic [bfp_pkg::MAX_FIELD_BITS-1:0] value_in,
                                   logic flush_in);
            int unsigned                  nbits;
            int unsigned                  total;
            int unsigned                  nbytes;
            logic [63:0]                  kept;
            logic [bfp_pkg::ACC_BITS-1:0] acc;
            stream_byte_t                 entry;
            nbits  = (width_in > bfp_pkg::MAX_FIELD_BITS) ? bfp_pkg::MAX_FIELD_BITS : width_in;
            kept   = {32'b0, value_in} & ((64'd1 << nbits) - 64'd1);
            acc    = {32'b0, partial_byte} | (kept[bfp_pkg::ACC_BITS-1:0] << fill_count);
            total  = fill_count + nbits;
            nbytes = total / bfp_pkg::BYTE_BITS;
            if (flush_in && (total % bfp_pkg::BYTE_BITS) != 0)
                nbytes++;
            for (int i = 0; i < nbytes; i++)
            begin
                entry.data = acc[bfp_pkg::BYTE_BITS-1:0];
                entry.last = (i == nbytes - 1);
                bytes_due.push_back(entry);
                acc = acc >> bfp_pkg::BYTE_BITS;
            end
            // a flush leaves nothing behind and restarts at bit 0
            if (flush_in)
            begin
                partial_byte = '0;
                fill_count   = '0;
            end
            else
            begin
                partial_byte = acc[bfp_pkg::BYTE_BITS-1:0];
                fill_count   = bfp_pkg::CNT_BITS'(total % bfp_pkg::BYTE_BITS);
            end
        endfunction

        function void note_error();
            errors++;
        endfunction

        // compare an emitted byte with the oldest one owed
        function void check_byte(logic [bfp_pkg::BYTE_BITS-1:0] data, logic last);
            stream_byte_t want;
            if (bytes_due.size() == 0)
            begin
                note_error();
                if (errors <= REPORT_MAX)
                    $display("mismatch: unexpected byte %02h last %0b", data, last);
            end
            else
            begin
                want = bytes_due.pop_front();
                if (want.data !== data || want.last !== last)
                begin
                    note_error();
                    if (errors <= REPORT_MAX)
                        $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 want.data, want.last, data, last);
                end
            end
        endfunction

        function int owed();
            return bytes_due.size();
        endfunction

        // bytes still owed at the end are failures
        function void close_stream();
            if (bytes_due.size() != 0)
            begin
                errors += bytes_due.size();
                $display("%0d bytes never emitted", bytes_due.size());
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [bfp_pkg::CNT_BITS-1:0]       cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    logic [bfp_pkg::WIDTH_BITS-1:0]     field_width;
    logic [bfp_pkg::MAX_FIELD_BITS-1:0] field_value;
    logic                               flush;
    logic                               out_valid;
    logic                               out_ready;
    logic [bfp_pkg::BYTE_BITS-1:0]      out_byte;
    logic                               last_of_run;

    byte_stream_checker stream = new();
    bit                 steady_tail;
    int                 idle_cycles;

    lsb_first_bit_field_packer_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .field_width (field_width),
        .field_value (field_value),
        .flush       (flush),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // observe every transfer on the three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                stream.restart(cfg_data);
            if (in_valid && in_ready)
                stream.append_field(field_width, field_value, flush);
            if (out_valid && out_ready)
                stream.check_byte(out_byte, last_of_run);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
            (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver stalls in random bursts, none in the steady tail
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!steady_tail && rst_n && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    // one field transfer, with an optional gap in front
    task automatic send_field(input logic [bfp_pkg::WIDTH_BITS-1:0] width_in,
                              input logic [bfp_pkg::MAX_FIELD_BITS-1:0] value_in,
                              input logic flush_in);
        @(negedge clk);
        if (!steady_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid    = 1'b1;
        field_width = width_in;
        field_value = value_in;
        flush       = flush_in;
        do @(posedge clk); while (!in_ready);
    endtask

    // random field, mostly legal widths with a few oversized ones
    task automatic send_random_field();
        logic [bfp_pkg::WIDTH_BITS-1:0]     width_pick;
        logic [bfp_pkg::MAX_FIELD_BITS-1:0] value_pick;
        int unsigned                        sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            width_pick = bfp_pkg::WIDTH_BITS'($urandom_range(33, 63));
        else if (sel < 3)
            width_pick = bfp_pkg::WIDTH_SAT;
        else
            width_pick = bfp_pkg::WIDTH_BITS'($urandom_range(0, 31));
        value_pick = ($urandom_range(0, 7) == 0) ? '1 : $urandom;
        send_field(width_pick, value_pick, $urandom_range(0, 4) == 0);
    endtask

    // hold off input until every owed byte has left, then let the core settle
    task automatic wait_stream_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (stream.owed() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // start bit write, only while the stream is idle
    task automatic write_start_bit(input logic [bfp_pkg::CNT_BITS-1:0] start_bit);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = start_bit;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [bfp_pkg::CNT_BITS-1:0] phase_start;
        rst_n       = 1'b0;
        steady_tail = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        field_width = '0;
        field_value = '0;
        flush       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stream from reset: empty fields, full bytes, oversized widths, flushes
        send_field(6'd0, 32'h0000_0000, 1'b0);
        send_field(6'd0, 32'hFFFF_FFFF, 1'b1);
        send_field(6'd8, 32'h0000_00A5, 1'b0);
        send_field(bfp_pkg::WIDTH_SAT, 32'hFFFF_FFFF, 1'b0);
        send_field(bfp_pkg::WIDTH_SAT, 32'h0000_0000, 1'b0);
        send_field(6'd4, 32'hFFFF_FFF9, 1'b0);
        send_field(6'd63, 32'h1234_5678, 1'b0);
        send_field(6'd33, 32'h89AB_CDEF, 1'b0);
        send_field(6'd3, 32'h0000_0007, 1'b1);
        send_field(6'd5, 32'h0000_0015, 1'b0);
        send_field(6'd0, 32'h0000_0000, 1'b1);
        // seven pending bits plus a full field gives the longest run
        send_field(6'd7, 32'h0000_007F, 1'b0);
        send_field(bfp_pkg::WIDTH_SAT, 32'hDEAD_BEEF, 1'b1);
        send_field(6'd1, 32'h0000_0001, 1'b0);
        send_field(6'd31, $urandom, 1'b1);

        // highest start bit: flush of an offset with no data, then restart at bit 0
        wait_stream_idle();
        write_start_bit(3'd7);
        send_field(6'd0, 32'h0000_0000, 1'b1);
        send_field(6'd1, 32'h0000_0001, 1'b0);
        send_field(bfp_pkg::WIDTH_SAT, 32'hFFFF_FFFF, 1'b1);
        wait_stream_idle();
        write_start_bit(3'd7);
        send_field(6'd1, 32'h0000_0001, 1'b0);
        send_field(6'd16, 32'hFFFF_A5A5, 1'b1);

        // a write drops the partial byte left behind
        wait_stream_idle();
        send_field(6'd3, 32'h0000_0005, 1'b0);
        wait_stream_idle();
        write_start_bit(3'd3);
        send_field(6'd5, 32'h0000_001F, 1'b0);
        send_field(6'd0, 32'h0000_0000, 1'b1);

        // random phases, each with its own start bit
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_stream_idle();
            if (phase == 0)
                phase_start = '0;
            else if (phase == 1)
                phase_start = '1;
            else
                phase_start = bfp_pkg::CNT_BITS'($urandom_range(0, 7));
            write_start_bit(phase_start);
            if (phase == RAND_PHASES - 1)
                steady_tail = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random_field();
                if (phase == 2 && i == PHASE_ITEMS / 2)
                    wait_stream_idle();
            end
        end

        // drain and look for stray bytes
        wait_stream_idle();
        repeat (SETTLE_CYC) @(posedge clk);
        stream.close_stream();
        if (stream.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bfp_pkg.sv
rtl/bfp_merge.sv
rtl/bfp_emit.sv
rtl/lsb_first_bit_field_packer_core.sv
rtl/bfp_checker.sv
test/testbench.sv
